// ===== design/tae_pkg.sv =====
// Shared types and constants for the text art extent measure block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package tae_pkg;

    localparam int TEXT_W   = 8;
    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 8'd1;

    localparam logic [WIDTH_W-1:0]  RESET_MAX_WIDTH  = 9'd400;
    localparam logic [HEIGHT_W-1:0] RESET_MAX_HEIGHT = 8'd200;

    // Byte codes
    localparam logic [TEXT_W-1:0] ESC_BYTE      = 8'h1b;
    localparam logic [TEXT_W-1:0] CSI_OPEN      = 8'h5b;
    localparam logic [TEXT_W-1:0] LF_BYTE       = 8'h0a;
    localparam logic [TEXT_W-1:0] CR_BYTE       = 8'h0d;
    localparam logic [TEXT_W-1:0] CSI_FINAL_LOW = 8'h40;
    localparam logic [TEXT_W-1:0] CONT_MASK     = 8'hc0;
    localparam logic [TEXT_W-1:0] CONT_BITS     = 8'h80;

    typedef enum logic [2:0] {
        MODE_PLAIN     = 3'b001,
        MODE_AFTER_ESC = 3'b010,
        MODE_IN_CSI    = 3'b100
    } t_scan_mode;

    typedef struct packed {
        logic [TEXT_W-1:0] text_byte;
        logic              end_of_file;
    } t_item;

    typedef struct packed {
        logic [WIDTH_W-1:0]  art_width;
        logic [HEIGHT_W-1:0] art_height;
    } t_result;

endpackage

// ===== design/tae_scan.sv =====
// Scan state and per-byte step logic: escape tracking, column/line counting, final clamp.
// Depends on tae_pkg.
`timescale 1ns / 1ps

module tae_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  tae_pkg::t_item               i_item,
    input  logic [tae_pkg::WIDTH_W-1:0]  i_max_width,
    input  logic [tae_pkg::HEIGHT_W-1:0] i_max_height,
    output tae_pkg::t_result             o_result
);

    tae_pkg::t_scan_mode          r_mode,   n_mode;
    logic [tae_pkg::WIDTH_W-1:0]  r_column, n_column;
    logic [tae_pkg::WIDTH_W-1:0]  r_widest, n_widest;
    logic [tae_pkg::HEIGHT_W-1:0] r_lines,  n_lines;
    logic                         r_seen,   n_seen;

    logic [tae_pkg::WIDTH_W-1:0]  wide;
    logic [tae_pkg::HEIGHT_W:0]   rows;
    logic [tae_pkg::TEXT_W-1:0]   c;

    assign c = i_item.text_byte;

    always_comb begin
        n_mode   = r_mode;
        n_column = r_column;
        n_widest = r_widest;
        n_lines  = r_lines;
        n_seen   = r_seen;
        case (r_mode)
            tae_pkg::MODE_AFTER_ESC: begin
                n_mode = (c == tae_pkg::CSI_OPEN) ? tae_pkg::MODE_IN_CSI : tae_pkg::MODE_PLAIN;
            end
            tae_pkg::MODE_IN_CSI: begin
                if (c >= tae_pkg::CSI_FINAL_LOW) begin
                    n_mode = tae_pkg::MODE_PLAIN;
                end
            end
            default: begin
                if (c == tae_pkg::ESC_BYTE) begin
                    n_mode = tae_pkg::MODE_AFTER_ESC;
                end else if (c == tae_pkg::LF_BYTE) begin
                    if (r_lines < i_max_height) begin
                        n_lines = r_lines + 1'b1;
                    end
                    if (r_column > r_widest) begin
                        n_widest = r_column;
                    end
                    n_column = '0;
                end else if (c == tae_pkg::CR_BYTE) begin
                    n_mode = r_mode;
                end else if ((c & tae_pkg::CONT_MASK) != tae_pkg::CONT_BITS) begin
                    if (r_column < i_max_width) begin
                        n_column = r_column + 1'b1;
                    end
                    n_seen = 1'b1;
                end
            end
        endcase
    end

    // Result as seen after this byte; used only when the byte closes the file
    always_comb begin
        wide = (n_column > n_widest) ? n_column : n_widest;
        rows = {1'b0, n_lines};
        if ((n_column != '0) || (n_seen && (n_lines == '0))) begin
            rows = {1'b0, n_lines} + 1'b1;
        end
        if (wide > i_max_width) begin
            wide = i_max_width;
        end
        if (rows > {1'b0, i_max_height}) begin
            rows = {1'b0, i_max_height};
        end
        o_result.art_width  = wide;
        o_result.art_height = rows[tae_pkg::HEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tae_pkg::MODE_PLAIN;
            r_column <= '0;
            r_widest <= '0;
            r_lines  <= '0;
            r_seen   <= 1'b0;
        end else if (i_step) begin
            if (i_item.end_of_file) begin
                r_mode   <= tae_pkg::MODE_PLAIN;
                r_column <= '0;
                r_widest <= '0;
                r_lines  <= '0;
                r_seen   <= 1'b0;
            end else begin
                r_mode   <= n_mode;
                r_column <= n_column;
                r_widest <= n_widest;
                r_lines  <= n_lines;
                r_seen   <= n_seen;
            end
        end
    end

endmodule

// ===== design/tae_out_reg.sv =====
// Result register with valid/ready handshake towards the consumer.
// Depends on tae_pkg.
`timescale 1ns / 1ps

module tae_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tae_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output tae_pkg::t_result o_result
);

    logic             r_valid;
    tae_pkg::t_result r_result;

    // Slot is free when empty or being drained this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_push || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/text_art_extent_measure_unit.sv =====
// Text art extent measure: an accepted item is held in the input register, and a closing
// item's result is loaded into the result register that drives o_valid. Throughput one item
// per cycle while not stalled; an end-of-file item stalls the input register only while the
// result register is full and not being taken. Synchronous active-low reset clears the scan
// state and pipeline valids and sets max_width to 400 and max_height to 200.
// Depends on tae_pkg, tae_scan and tae_out_reg.
`timescale 1ns / 1ps

module text_art_extent_measure_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte stream in
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tae_pkg::TEXT_W-1:0]     i_text_byte,
    input  logic                           i_end_of_file,
    // result out
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tae_pkg::WIDTH_W-1:0]    o_art_width,
    output logic [tae_pkg::HEIGHT_W-1:0]   o_art_height,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tae_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [tae_pkg::WIDTH_W-1:0]  r_max_width;
    logic [tae_pkg::HEIGHT_W-1:0] r_max_height;

    // Input register stage
    logic           r_s1_valid;
    tae_pkg::t_item r_s1_item;

    logic             s1_advance;
    logic             out_free;
    logic             push;
    tae_pkg::t_result step_result;
    tae_pkg::t_result out_result;

    // Always take configuration writes; out-of-range indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= tae_pkg::RESET_MAX_WIDTH;
            r_max_height <= tae_pkg::RESET_MAX_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tae_pkg::REG_MAX_WIDTH:  r_max_width  <= i_cfg_data;
                tae_pkg::REG_MAX_HEIGHT: r_max_height <= i_cfg_data[tae_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the held item unless it carries a result and the result slot is occupied and not being drained
    assign s1_advance = r_s1_valid && (!r_s1_item.end_of_file || out_free);
    assign push       = s1_advance && r_s1_item.end_of_file;
    assign o_ready    = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Load the payload whenever the stage is free to take a new item
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1_item.text_byte   <= i_text_byte;
            r_s1_item.end_of_file <= i_end_of_file;
        end
    end

    tae_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_advance),
        .i_item       (r_s1_item),
        .i_max_width  (r_max_width),
        .i_max_height (r_max_height),
        .o_result     (step_result)
    );

    tae_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_art_width  = out_result.art_width;
    assign o_art_height = out_result.art_height;

    // A pending end-of-file item must not overwrite an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_item.end_of_file && o_valid && !i_ready) |-> !o_ready)
        else $error("result register would be overwritten");

    // A closing item that advances shows its result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("result missing after end of file");

    // Input backpressure only while an item is held
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && r_s1_item.end_of_file))
        else $error("input stalled without a held closing item");

endmodule

// ===== tb/text_art_extent_measure_unit_tb.sv =====
// Self-checking testbench for text_art_extent_measure_unit: streams text files byte by byte,
// predicts each width/height result in a scoreboard class and compares every result taken.
// Depends on tae_pkg and the design files only.
`timescale 1ns / 1ps

class extent_scoreboard;

    tae_pkg::t_result    pending_extents[$];
    tae_pkg::t_scan_mode scan;
    logic [8:0]          column;
    logic [8:0]          widest;
    logic [7:0]          lines;
    logic                seen_cell;
    logic [8:0]          lim_width;
    logic [7:0]          lim_height;
    int                  errors;

    function new();
        lim_width  = tae_pkg::RESET_MAX_WIDTH;
        lim_height = tae_pkg::RESET_MAX_HEIGHT;
        errors     = 0;
        clear_file();
    endfunction

    function void clear_file();
        scan      = tae_pkg::MODE_PLAIN;
        column    = '0;
        widest    = '0;
        lines     = '0;
        seen_cell = 1'b0;
    endfunction

    function void write_register(logic [7:0] idx, logic [8:0] data);
        if (idx == tae_pkg::REG_MAX_WIDTH) begin
            lim_width = data;
        end else if (idx == tae_pkg::REG_MAX_HEIGHT) begin
            lim_height = data[7:0];
        end
    endfunction

    // Advance the scan state by one byte; on the last byte queue the extent and start afresh.
    function void note_byte(logic [7:0] c, logic last);
        logic [8:0]       wide;
        logic [8:0]       rows;
        tae_pkg::t_result extent;
        case (scan)
            tae_pkg::MODE_AFTER_ESC: begin
                if (c == tae_pkg::CSI_OPEN) scan = tae_pkg::MODE_IN_CSI;
                else scan = tae_pkg::MODE_PLAIN;
            end
            tae_pkg::MODE_IN_CSI: begin
                if (c >= tae_pkg::CSI_FINAL_LOW) scan = tae_pkg::MODE_PLAIN;
            end
            default: begin
                if (c == tae_pkg::ESC_BYTE) begin
                    scan = tae_pkg::MODE_AFTER_ESC;
                end else if (c == tae_pkg::LF_BYTE) begin
                    if (lines < lim_height) lines = lines + 8'd1;
                    if (column > widest) widest = column;
                    column = '0;
                end else if (c != tae_pkg::CR_BYTE &&
                             (c & tae_pkg::CONT_MASK) != tae_pkg::CONT_BITS) begin
                    if (column < lim_width) column = column + 9'd1;
                    seen_cell = 1'b1;
                end
            end
        endcase
        if (!last) return;
        wide = (column > widest) ? column : widest;
        rows = {1'b0, lines};
        if (column != 0 || (seen_cell && lines == 0)) rows = rows + 9'd1;
        if (wide > lim_width) wide = lim_width;
        if (rows > {1'b0, lim_height}) rows = {1'b0, lim_height};
        extent.art_width  = wide;
        extent.art_height = rows[7:0];
        pending_extents.push_back(extent);
        clear_file();
    endfunction

    function void check_extent(logic [8:0] got_width, logic [7:0] got_height);
        tae_pkg::t_result want;
        if (pending_extents.size() == 0) begin
            $display("%0t: unexpected result, art_width %0d art_height %0d",
                     $time, got_width, got_height);
            errors++;
            return;
        end
        want = pending_extents.pop_front();
        if (got_width != want.art_width) begin
            $display("%0t: art_width expected %0d, actual %0d",
                     $time, want.art_width, got_width);
            errors++;
        end
        if (got_height != want.art_height) begin
            $display("%0t: art_height expected %0d, actual %0d",
                     $time, want.art_height, got_height);
            errors++;
        end
    endfunction

endclass

module text_art_extent_measure_unit_tb;

    import tae_pkg::*;

    // Longest stretch without any handshake is a sender gap plus a receiver stall plus the
    // pipeline registers, so this limit leaves a wide margin.
    localparam int STALL_LIMIT = 600;
    localparam int DRAIN_CYCLES = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [TEXT_W-1:0]     i_text_byte;
    logic                  i_end_of_file;
    logic                  o_valid;
    logic                  i_ready;
    logic [WIDTH_W-1:0]    o_art_width;
    logic [HEIGHT_W-1:0]   o_art_height;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    extent_scoreboard scoreboard = new();

    logic [7:0]  file_bytes[$];
    int unsigned items_sent;
    int unsigned quiet_cycles;
    bit          feed_burst;
    bit          drain_burst;

    text_art_extent_measure_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_file (i_end_of_file),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_art_width   (o_art_width),
        .o_art_height  (o_art_height),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which no channel moves anything; reset counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Per-item wait draws; a burst flag flips now and then to give runs with no idling.
    function automatic int unsigned next_feed_gap();
        if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
        return feed_burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int unsigned next_drain_gap();
        if ($urandom_range(0, 29) == 0) drain_burst = !drain_burst;
        return drain_burst ? 0 : $urandom_range(0, 13);
    endfunction

    // Result side: stall for a drawn number of cycles, then hold ready until an item is taken.
    initial begin
        int unsigned stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = next_drain_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            scoreboard.check_extent(o_art_width, o_art_height);
        end
    end

    // Offer one byte after a drawn gap and hold it until accepted. Valid is left high on
    // return so that a back-to-back byte never sees valid dropped and raised in one step.
    task automatic send_byte(input logic [7:0] text, input logic last);
        int unsigned gap;
        gap = next_feed_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= text;
        i_end_of_file <= last;
        do @(posedge i_clk); while (!o_ready);
        scoreboard.note_byte(text, last);
        items_sent++;
    endtask

    task automatic send_queued(input logic closed);
        int k;
        for (k = 0; k < file_bytes.size(); k++) begin
            send_byte(file_bytes[k], closed && (k == file_bytes.size() - 1));
        end
    endtask

    // Append one token of text: mostly printable cells and line feeds, with well-formed
    // escape sequences and UTF-8 runs, and some raw noise bytes mixed in.
    function automatic void add_token();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            file_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else if (pick < 55) begin
            file_bytes.push_back(LF_BYTE);
        end else if (pick < 60) begin
            file_bytes.push_back(CR_BYTE);
        end else if (pick < 68) begin
            file_bytes.push_back(8'($urandom_range(8'hc0, 8'hff)));
            n = $urandom_range(0, 3);
            repeat (n) file_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else if (pick < 74) begin
            file_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else if (pick < 86) begin
            // control sequence: parameters below 0x40, then a final byte at or above it
            file_bytes.push_back(ESC_BYTE);
            file_bytes.push_back(CSI_OPEN);
            n = $urandom_range(0, 4);
            repeat (n) file_bytes.push_back(8'($urandom_range(8'h00, 8'h3f)));
            file_bytes.push_back(8'($urandom_range(8'h40, 8'hff)));
        end else if (pick < 90) begin
            file_bytes.push_back(ESC_BYTE);
            file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Build a file of random length and send it; an open file is left without its last mark.
    task automatic send_file(input logic closed);
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 20);
        file_bytes.delete();
        while (file_bytes.size() < len) add_token();
        while (file_bytes.size() > len) void'(file_bytes.pop_back());
        send_queued(closed);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        scoreboard.write_register(idx, data);
    endtask

    // Pick the limits for a phase: zero, one and full scale first, then a random mix that
    // favours small limits so that saturation is reached by short files.
    task automatic set_limits(input int unsigned phase);
        logic [8:0]  w_lim;
        logic [8:0]  h_lim;
        int unsigned pick;
        pick = (phase < 3) ? phase : $urandom_range(0, 7);
        case (pick)
            0: begin w_lim = 9'd0;   h_lim = 9'd0;   end
            1: begin w_lim = 9'd1;   h_lim = 9'd1;   end
            2: begin w_lim = 9'd511; h_lim = 9'd255; end
            3: begin w_lim = RESET_MAX_WIDTH; h_lim = {1'b0, RESET_MAX_HEIGHT}; end
            4, 5: begin
                w_lim = 9'($urandom_range(1, 12));
                h_lim = 9'($urandom_range(1, 6));
            end
            6: begin
                // height data may carry a ninth bit, which the register drops
                w_lim = 9'($urandom_range(0, 511));
                h_lim = 9'($urandom_range(0, 511));
            end
            default: begin
                w_lim = 9'($urandom_range(1, 40));
                h_lim = 9'($urandom_range(1, 20));
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(REG_MAX_WIDTH, w_lim);
            cfg_write(REG_MAX_HEIGHT, h_lim);
        end else begin
            cfg_write(REG_MAX_HEIGHT, h_lim);
            cfg_write(REG_MAX_WIDTH, w_lim);
        end
        // a write to an unused index must leave both limits alone
        if ($urandom_range(0, 3) == 0) cfg_write(8'($urandom_range(2, 255)), 9'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering bytes, let every expected result come out, then allow for bytes that
    // are still in the pipeline but cause no result.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (scoreboard.pending_extents.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned n_files;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_text_byte   <= '0;
        i_end_of_file <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        feed_burst    = 1'b0;
        items_sent    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files at the reset limits.
        send_byte(8'h41, 1'b1);              // one cell, no line feed: one line
        send_byte(LF_BYTE, 1'b1);            // a lone line feed: empty line, no width
        send_byte(ESC_BYTE, 1'b0);           // control sequence with parameters
        send_byte(CSI_OPEN, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h31, 1'b0);
        send_byte(8'h6d, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(CR_BYTE, 1'b0);            // carriage return takes no cell
        send_byte(8'hc3, 1'b0);              // two-byte UTF-8 character: one cell
        send_byte(8'ha9, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);           // short escape: the next byte is skipped
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);              // stray continuation bytes
        send_byte(8'hbf, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h61, 1'b0);              // empty last line is not counted
        send_byte(8'h62, 1'b0);
        send_byte(LF_BYTE, 1'b1);
        send_byte(8'h7a, 1'b0);              // escape still open on the last byte
        send_byte(ESC_BYTE, 1'b0);
        send_byte(CSI_OPEN, 1'b1);

        // One tall, wide file at the reset limits so that both counters saturate.
        file_bytes.delete();
        repeat (405) file_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        repeat (205) begin
            file_bytes.push_back(LF_BYTE);
            if ($urandom_range(0, 1) == 1) file_bytes.push_back(8'h78);
        end
        file_bytes.push_back(8'h71);
        send_queued(1'b1);

        // Random phases: new limits while idle, then a few files; a phase may end in the
        // middle of a file so that the next limits apply to the rest of it.
        phase = 0;
        while (items_sent < 1000) begin
            drain_block();
            set_limits(phase);
            n_files = $urandom_range(2, 8);
            repeat (n_files) send_file(1'b1);
            if ($urandom_range(0, 2) == 0) send_file(1'b0);
            phase++;
        end
        drain_block();

        if (scoreboard.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
